@@ rtl/lirs_pkg.sv @@
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types and constants of the LIRS replacement core: entry status
// codes, cell commands, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int KEY_BITS_DEF    = 16;
    localparam int DATA_BITS_DEF   = 32;

    // configuration register widths and reset values
    localparam int STACK_LIMIT_W = 6;
    localparam int HIR_LIMIT_W   = 4;
    localparam int LIR_LIMIT_W   = 5;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 6;

    localparam logic [STACK_LIMIT_W-1:0] STACK_LIMIT_RST = 6'd32;
    localparam logic [HIR_LIMIT_W-1:0]   HIR_LIMIT_RST   = 4'd4;
    localparam logic [LIR_LIMIT_W-1:0]   LIR_LIMIT_RST   = 5'd16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_STACK_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIR_LIMIT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIR_LIMIT   = 2'd2;

    // status of a recency stack entry
    typedef enum logic [1:0] {
        ST_EMPTY  = 2'd0,
        ST_LIR    = 2'd1,
        ST_HIR    = 2'd2,
        ST_NONRES = 2'd3
    } entry_status_t;

    // per-cell command for one cycle
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_PREV  = 3'd1,
        CELL_NEXT  = 3'd2,
        CELL_LOAD  = 3'd3,
        CELL_MARK  = 3'd4,
        CELL_CLEAR = 3'd5
    } cell_cmd_t;

endpackage

@@ rtl/lirs_stack_cell.sv @@
// ----------------------------------------------------------------------------
// lirs_stack_cell
// One entry of the recency stack: key, data and status. Each cycle it holds,
// takes its upper or lower neighbor, loads the shared bus, or changes status.
// ----------------------------------------------------------------------------
module lirs_stack_cell #(
    parameter int KEY_BITS  = lirs_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = lirs_pkg::DATA_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lirs_pkg::cell_cmd_t     cmd,
    input  logic [KEY_BITS-1:0]     prev_key,
    input  logic [DATA_BITS-1:0]    prev_data,
    input  lirs_pkg::entry_status_t prev_stat,
    input  logic [KEY_BITS-1:0]     next_key,
    input  logic [DATA_BITS-1:0]    next_data,
    input  lirs_pkg::entry_status_t next_status,
    input  logic [KEY_BITS-1:0]     load_key,
    input  logic [DATA_BITS-1:0]    load_data,
    input  lirs_pkg::entry_status_t load_status,
    output logic [KEY_BITS-1:0]     key,
    output logic [DATA_BITS-1:0]    data,
    output lirs_pkg::entry_status_t status
);

    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [DATA_BITS-1:0]    data_reg, data_next;
    lirs_pkg::entry_status_t status_reg, status_next;

    // select the new content
    always_comb begin
        key_next    = key_reg;
        data_next   = data_reg;
        status_next = status_reg;
        unique case (cmd)
            lirs_pkg::CELL_PREV: begin
                key_next    = prev_key;
                data_next   = prev_data;
                status_next = prev_stat;
            end
            lirs_pkg::CELL_NEXT: begin
                key_next    = next_key;
                data_next   = next_data;
                status_next = next_status;
            end
            lirs_pkg::CELL_LOAD: begin
                key_next    = load_key;
                data_next   = load_data;
                status_next = load_status;
            end
            lirs_pkg::CELL_MARK:  status_next = load_status;
            lirs_pkg::CELL_CLEAR: status_next = lirs_pkg::ST_EMPTY;
            default: begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= lirs_pkg::ST_EMPTY;
        end else begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key    = key_reg;
    assign data   = data_reg;
    assign status = status_reg;

endmodule

@@ rtl/lirs_queue_cell.sv @@
// ----------------------------------------------------------------------------
// lirs_queue_cell
// One slot of the resident HIR queue: key and data. Each cycle it holds,
// takes the slot behind it (queue moves toward the head), or loads the bus.
// ----------------------------------------------------------------------------
module lirs_queue_cell #(
    parameter int KEY_BITS  = lirs_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS = lirs_pkg::DATA_BITS_DEF
) (
    input  logic                 aclk,
    input  lirs_pkg::cell_cmd_t  cmd,
    input  logic [KEY_BITS-1:0]  next_key,
    input  logic [DATA_BITS-1:0] next_data,
    input  logic [KEY_BITS-1:0]  load_key,
    input  logic [DATA_BITS-1:0] load_data,
    output logic [KEY_BITS-1:0]  key,
    output logic [DATA_BITS-1:0] data
);

    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] data_reg, data_next;

    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        unique case (cmd)
            lirs_pkg::CELL_NEXT: begin
                key_next  = next_key;
                data_next = next_data;
            end
            lirs_pkg::CELL_LOAD: begin
                key_next  = load_key;
                data_next = load_data;
            end
            default: begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key  = key_reg;
    assign data = data_reg;

endmodule

@@ rtl/lirs_cache_replacement_core.sv @@
// ----------------------------------------------------------------------------
// lirs_cache_replacement_core
// Fully associative cache under LIRS replacement, built as a row of stack
// cells and a row of queue cells driven by a step sequencer.
// ----------------------------------------------------------------------------
// One access is taken at a time. From accept to the result register it
// goes through a lookup step, then a step for each thing the access needs
// (queue removal or eviction, room making and push or move to top, LIR
// demotion or queue insert), the prune of the stack bottom, and a step that
// loads the result register. Each step is done in parallel by all cells.
// The next access is taken in the cycle after the result register is
// loaded, even if that result is still waiting on m_tready. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module lirs_cache_replacement_core #(
    parameter int STACK_DEPTH = lirs_pkg::STACK_DEPTH_DEF,
    parameter int QUEUE_DEPTH = lirs_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = lirs_pkg::KEY_BITS_DEF,
    parameter int DATA_BITS   = lirs_pkg::DATA_BITS_DEF,
    localparam int IN_W  = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((KEY_BITS + DATA_BITS + 2 + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,   // access_key, fill_data
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,   // hit, read_data, evict_valid, evicted_key
    input  logic                            cfg_we,
    input  logic [lirs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lirs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = (CW > lirs_pkg::STACK_LIMIT_W) ? CW : lirs_pkg::STACK_LIMIT_W;
    localparam int QEW = (QCW > lirs_pkg::HIR_LIMIT_W) ? QCW : lirs_pkg::HIR_LIMIT_W;
    localparam int OUT_BITS = KEY_BITS + DATA_BITS + 2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_FIND   = 10'b00_0000_0010,
        S_QREM   = 10'b00_0000_0100,
        S_ROOM   = 10'b00_0000_1000,
        S_PUSH   = 10'b00_0001_0000,
        S_TOP    = 10'b00_0010_0000,
        S_DEMOTE = 10'b00_0100_0000,
        S_QPUSH  = 10'b00_1000_0000,
        S_PRUNE  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    // ---------------- configuration ----------------
    logic [lirs_pkg::STACK_LIMIT_W-1:0] stack_limit_reg;
    logic [lirs_pkg::HIR_LIMIT_W-1:0]   hir_limit_reg;
    logic [lirs_pkg::LIR_LIMIT_W-1:0]   lir_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_limit_reg <= lirs_pkg::STACK_LIMIT_RST;
            hir_limit_reg   <= lirs_pkg::HIR_LIMIT_RST;
            lir_limit_reg   <= lirs_pkg::LIR_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                lirs_pkg::CFG_STACK_LIMIT: stack_limit_reg <= cfg_wdata;
                lirs_pkg::CFG_HIR_LIMIT:
                    hir_limit_reg <= cfg_wdata[lirs_pkg::HIR_LIMIT_W-1:0];
                lirs_pkg::CFG_LIR_LIMIT:
                    lir_limit_reg <= cfg_wdata[lirs_pkg::LIR_LIMIT_W-1:0];
                default: begin
                    stack_limit_reg <= stack_limit_reg;
                end
            endcase
        end
    end

    // clamp the limits to their legal ranges
    logic [EW-1:0]  eff_stack, eff_lir;
    logic [QEW-1:0] eff_hir;

    always_comb begin
        if (stack_limit_reg == '0) begin
            eff_stack = EW'(1);
        end else if (EW'(stack_limit_reg) > EW'(STACK_DEPTH)) begin
            eff_stack = EW'(STACK_DEPTH);
        end else begin
            eff_stack = EW'(stack_limit_reg);
        end
        if (hir_limit_reg == '0) begin
            eff_hir = QEW'(1);
        end else if (QEW'(hir_limit_reg) > QEW'(QUEUE_DEPTH)) begin
            eff_hir = QEW'(QUEUE_DEPTH);
        end else begin
            eff_hir = QEW'(hir_limit_reg);
        end
        if (lir_limit_reg == '0) begin
            eff_lir = EW'(1);
        end else if (EW'(lir_limit_reg) > eff_stack) begin
            eff_lir = eff_stack;
        end else begin
            eff_lir = EW'(lir_limit_reg);
        end
    end

    // ---------------- cell rows ----------------
    logic [KEY_BITS-1:0]     sk [STACK_DEPTH];
    logic [DATA_BITS-1:0]    sd [STACK_DEPTH];
    lirs_pkg::entry_status_t ss [STACK_DEPTH];
    lirs_pkg::cell_cmd_t     scmd [STACK_DEPTH];
    logic [KEY_BITS-1:0]     qk [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]    qd [QUEUE_DEPTH];
    lirs_pkg::cell_cmd_t     qcmd [QUEUE_DEPTH];

    logic [KEY_BITS-1:0]     ld_key_bus;
    logic [DATA_BITS-1:0]    ld_data_bus;
    lirs_pkg::entry_status_t ld_status_bus;
    logic [KEY_BITS-1:0]     qld_key_bus;
    logic [DATA_BITS-1:0]    qld_data_bus;

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_stack
            logic [KEY_BITS-1:0]     pk, nk;
            logic [DATA_BITS-1:0]    pd, nd;
            lirs_pkg::entry_status_t ps, ns;
            if (g == 0) begin : g_first
                assign pk = ld_key_bus;
                assign pd = ld_data_bus;
                assign ps = ld_status_bus;
            end else begin : g_mid
                assign pk = sk[g-1];
                assign pd = sd[g-1];
                assign ps = ss[g-1];
            end
            if (g == STACK_DEPTH - 1) begin : g_last
                assign nk = sk[g];
                assign nd = sd[g];
                assign ns = lirs_pkg::ST_EMPTY;
            end else begin : g_inner
                assign nk = sk[g+1];
                assign nd = sd[g+1];
                assign ns = ss[g+1];
            end
            lirs_stack_cell #(
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (scmd[g]),
                .prev_key    (pk),
                .prev_data   (pd),
                .prev_stat   (ps),
                .next_key    (nk),
                .next_data   (nd),
                .next_status (ns),
                .load_key    (ld_key_bus),
                .load_data   (ld_data_bus),
                .load_status (ld_status_bus),
                .key         (sk[g]),
                .data        (sd[g]),
                .status      (ss[g])
            );
        end

        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_queue
            logic [KEY_BITS-1:0]  nk;
            logic [DATA_BITS-1:0] nd;
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign nk = qk[g];
                assign nd = qd[g];
            end else begin : g_inner
                assign nk = qk[g+1];
                assign nd = qd[g+1];
            end
            lirs_queue_cell #(
                .KEY_BITS  (KEY_BITS),
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (qcmd[g]),
                .next_key  (nk),
                .next_data (nd),
                .load_key  (qld_key_bus),
                .load_data (qld_data_bus),
                .key       (qk[g]),
                .data      (qd[g])
            );
        end
    endgenerate

    // ---------------- control registers ----------------
    state_t                  state_reg, state_next;
    logic [CW-1:0]           s_cnt_reg, s_cnt_next;
    logic [CW-1:0]           lir_cnt_reg, lir_cnt_next;
    logic [QCW-1:0]          q_cnt_reg, q_cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [DATA_BITS-1:0]    fill_reg, fill_next;
    logic                    hit_reg, hit_next;
    logic [DATA_BITS-1:0]    rd_reg, rd_next;
    logic                    ev_reg, ev_next;
    logic [KEY_BITS-1:0]     evk_reg, evk_next;
    logic                    do_qrem_reg, do_qrem_next;
    logic                    mark_reg, mark_next;
    logic [QIW-1:0]          qrem_idx_reg, qrem_idx_next;
    logic                    do_push_reg, do_push_next;
    logic [SIW-1:0]          top_idx_reg, top_idx_next;
    lirs_pkg::entry_status_t ld_status_reg, ld_status_next;
    logic [DATA_BITS-1:0]    ld_data_reg, ld_data_next;
    logic                    set_lir_reg, set_lir_next;
    logic                    do_demote_reg, do_demote_next;
    logic                    do_qpush_reg, do_qpush_next;
    logic [DATA_BITS-1:0]    qpush_data_reg, qpush_data_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;

    // ---------------- searches over the rows ----------------
    logic           s_found, q_found;
    logic [SIW-1:0] s_idx;
    logic [QIW-1:0] q_idx;
    logic           lir_any, nonres_any, hir_any, victim_any;
    logic [SIW-1:0] lir_bot, nonres_bot, hir_bot, victim;
    logic           stack_full, demote_go;

    always_comb begin
        s_found = 1'b0;
        s_idx   = '0;
        for (int j = STACK_DEPTH - 1; j >= 0; j--) begin
            if (ss[j] != lirs_pkg::ST_EMPTY && sk[j] == key_reg) begin
                s_found = 1'b1;
                s_idx   = SIW'(j);
            end
        end
        q_found = 1'b0;
        q_idx   = '0;
        for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
            if (QCW'(j) < q_cnt_reg && qk[j] == key_reg) begin
                q_found = 1'b1;
                q_idx   = QIW'(j);
            end
        end
        // bottom-most entry of each status
        lir_any    = 1'b0;
        nonres_any = 1'b0;
        hir_any    = 1'b0;
        lir_bot    = '0;
        nonres_bot = '0;
        hir_bot    = '0;
        for (int j = 0; j < STACK_DEPTH; j++) begin
            if (ss[j] == lirs_pkg::ST_LIR) begin
                lir_any = 1'b1;
                lir_bot = SIW'(j);
            end
            if (ss[j] == lirs_pkg::ST_NONRES) begin
                nonres_any = 1'b1;
                nonres_bot = SIW'(j);
            end
            if (ss[j] == lirs_pkg::ST_HIR) begin
                hir_any = 1'b1;
                hir_bot = SIW'(j);
            end
        end
        victim_any = nonres_any | hir_any;
        victim     = nonres_any ? nonres_bot : hir_bot;
        stack_full = (EW'(s_cnt_reg) >= eff_stack) || (s_cnt_reg == CW'(STACK_DEPTH));
        demote_go  = (EW'(lir_cnt_reg) > eff_lir) && lir_any;
    end

    // ---------------- cell commands and load buses ----------------
    always_comb begin
        ld_key_bus    = key_reg;
        ld_data_bus   = ld_data_reg;
        ld_status_bus = (state_reg == S_QREM) ? lirs_pkg::ST_NONRES : ld_status_reg;
        if (state_reg == S_DEMOTE) begin
            qld_key_bus  = sk[lir_bot];
            qld_data_bus = sd[lir_bot];
        end else begin
            qld_key_bus  = key_reg;
            qld_data_bus = qpush_data_reg;
        end

        for (int j = 0; j < STACK_DEPTH; j++) begin
            scmd[j] = lirs_pkg::CELL_HOLD;
            unique case (state_reg)
                S_QREM: begin
                    if (mark_reg && ss[j] != lirs_pkg::ST_EMPTY && sk[j] == qk[0]) begin
                        scmd[j] = lirs_pkg::CELL_MARK;
                    end
                end
                S_ROOM: begin
                    if (stack_full && victim_any && SIW'(j) >= victim) begin
                        scmd[j] = lirs_pkg::CELL_NEXT;
                    end
                end
                S_PUSH: begin
                    scmd[j] = (j == 0) ? lirs_pkg::CELL_LOAD : lirs_pkg::CELL_PREV;
                end
                S_TOP: begin
                    if (j == 0) begin
                        scmd[j] = lirs_pkg::CELL_LOAD;
                    end else if (SIW'(j) <= top_idx_reg) begin
                        scmd[j] = lirs_pkg::CELL_PREV;
                    end
                end
                S_DEMOTE: begin
                    if (demote_go && SIW'(j) >= lir_bot) begin
                        scmd[j] = lirs_pkg::CELL_NEXT;
                    end
                end
                S_PRUNE: begin
                    if (!lir_any || SIW'(j) > lir_bot) begin
                        scmd[j] = lirs_pkg::CELL_CLEAR;
                    end
                end
                default: begin
                    scmd[j] = lirs_pkg::CELL_HOLD;
                end
            endcase
        end

        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            qcmd[j] = lirs_pkg::CELL_HOLD;
            if (state_reg == S_QREM && QIW'(j) >= qrem_idx_reg) begin
                qcmd[j] = lirs_pkg::CELL_NEXT;
            end
            if ((state_reg == S_QPUSH || (state_reg == S_DEMOTE && demote_go))
                && QCW'(j) == q_cnt_reg) begin
                qcmd[j] = lirs_pkg::CELL_LOAD;
            end
        end
    end

    // ---------------- step sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        s_cnt_next      = s_cnt_reg;
        lir_cnt_next    = lir_cnt_reg;
        q_cnt_next      = q_cnt_reg;
        out_valid_next  = out_valid_reg;
        key_next        = key_reg;
        fill_next       = fill_reg;
        hit_next        = hit_reg;
        rd_next         = rd_reg;
        ev_next         = ev_reg;
        evk_next        = evk_reg;
        do_qrem_next    = do_qrem_reg;
        mark_next       = mark_reg;
        qrem_idx_next   = qrem_idx_reg;
        do_push_next    = do_push_reg;
        top_idx_next    = top_idx_reg;
        ld_status_next  = ld_status_reg;
        ld_data_next    = ld_data_reg;
        set_lir_next    = set_lir_reg;
        do_demote_next  = do_demote_reg;
        do_qpush_next   = do_qpush_reg;
        qpush_data_next = qpush_data_reg;
        out_data_next   = out_data_reg;

        // drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next   = s_tdata[KEY_BITS-1:0];
                    fill_next  = s_tdata[KEY_BITS+DATA_BITS-1:KEY_BITS];
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                // classify the access and plan its steps
                hit_next       = 1'b0;
                rd_next        = fill_reg;
                ev_next        = 1'b0;
                evk_next       = '0;
                do_qrem_next   = 1'b0;
                mark_next      = 1'b0;
                qrem_idx_next  = '0;
                do_push_next   = 1'b0;
                top_idx_next   = s_idx;
                ld_status_next = lirs_pkg::ST_LIR;
                ld_data_next   = fill_reg;
                set_lir_next   = 1'b0;
                do_demote_next = 1'b0;
                do_qpush_next  = 1'b0;
                qpush_data_next = fill_reg;
                if (s_found && ss[s_idx] == lirs_pkg::ST_LIR) begin
                    hit_next     = 1'b1;
                    rd_next      = sd[s_idx];
                    ld_data_next = sd[s_idx];
                end else if (q_found) begin
                    hit_next      = 1'b1;
                    rd_next       = qd[q_idx];
                    do_qrem_next  = 1'b1;
                    qrem_idx_next = q_idx;
                    if (s_found) begin
                        ld_data_next   = qd[q_idx];
                        set_lir_next   = 1'b1;
                        do_demote_next = 1'b1;
                    end else begin
                        do_push_next    = 1'b1;
                        ld_status_next  = lirs_pkg::ST_HIR;
                        ld_data_next    = '0;
                        do_qpush_next   = 1'b1;
                        qpush_data_next = qd[q_idx];
                    end
                end else if (EW'(lir_cnt_reg) < eff_lir) begin
                    if (s_found) begin
                        set_lir_next = 1'b1;
                    end else begin
                        do_push_next = 1'b1;
                    end
                end else begin
                    if (QEW'(q_cnt_reg) >= eff_hir && q_cnt_reg != '0) begin
                        ev_next      = 1'b1;
                        evk_next     = qk[0];
                        do_qrem_next = 1'b1;
                        mark_next    = 1'b1;
                    end
                    if (s_found) begin
                        set_lir_next   = 1'b1;
                        do_demote_next = 1'b1;
                    end else begin
                        do_push_next   = 1'b1;
                        ld_status_next = lirs_pkg::ST_HIR;
                        ld_data_next   = '0;
                        do_qpush_next  = 1'b1;
                    end
                end
                if (do_qrem_next) begin
                    state_next = S_QREM;
                end else if (do_push_next) begin
                    state_next = S_ROOM;
                end else begin
                    state_next = S_TOP;
                end
            end
            S_QREM: begin
                q_cnt_next = q_cnt_reg - QCW'(1);
                state_next = do_push_reg ? S_ROOM : S_TOP;
            end
            S_ROOM: begin
                if (stack_full && !victim_any) begin
                    state_next = do_qpush_reg ? S_QPUSH : S_PRUNE;
                end else begin
                    if (stack_full) begin
                        s_cnt_next = s_cnt_reg - CW'(1);
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                s_cnt_next = s_cnt_reg + CW'(1);
                if (ld_status_reg == lirs_pkg::ST_LIR) begin
                    lir_cnt_next = lir_cnt_reg + CW'(1);
                end
                state_next = do_qpush_reg ? S_QPUSH : S_PRUNE;
            end
            S_TOP: begin
                if (set_lir_reg) begin
                    lir_cnt_next = lir_cnt_reg + CW'(1);
                end
                state_next = do_demote_reg ? S_DEMOTE : S_PRUNE;
            end
            S_DEMOTE: begin
                if (demote_go) begin
                    s_cnt_next   = s_cnt_reg - CW'(1);
                    lir_cnt_next = lir_cnt_reg - CW'(1);
                    if (q_cnt_reg < QCW'(QUEUE_DEPTH)) begin
                        q_cnt_next = q_cnt_reg + QCW'(1);
                    end
                end
                state_next = S_PRUNE;
            end
            S_QPUSH: begin
                if (q_cnt_reg < QCW'(QUEUE_DEPTH)) begin
                    q_cnt_next = q_cnt_reg + QCW'(1);
                end
                state_next = S_PRUNE;
            end
            S_PRUNE: begin
                s_cnt_next = lir_any ? (CW'(lir_bot) + CW'(1)) : '0;
                state_next = S_DONE;
            end
            S_DONE: begin
                // hand the result to the output register
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({evk_reg, ev_reg, rd_reg, hit_reg});
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            s_cnt_reg     <= '0;
            lir_cnt_reg   <= '0;
            q_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            s_cnt_reg     <= s_cnt_next;
            lir_cnt_reg   <= lir_cnt_next;
            q_cnt_reg     <= q_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        fill_reg       <= fill_next;
        hit_reg        <= hit_next;
        rd_reg         <= rd_next;
        ev_reg         <= ev_next;
        evk_reg        <= evk_next;
        do_qrem_reg    <= do_qrem_next;
        mark_reg       <= mark_next;
        qrem_idx_reg   <= qrem_idx_next;
        do_push_reg    <= do_push_next;
        top_idx_reg    <= top_idx_next;
        ld_status_reg  <= ld_status_next;
        ld_data_reg    <= ld_data_next;
        set_lir_reg    <= set_lir_next;
        do_demote_reg  <= do_demote_next;
        do_qpush_reg   <= do_qpush_next;
        qpush_data_reg <= qpush_data_next;
        out_data_reg   <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_data_reg[OUT_BITS-1:0]};

endmodule
